FILE: hw/rtl/swdhte_pkg.sv
`default_nettype none

package swdhte_pkg;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ONES1 = 4'd1,
        PH_KEY   = 4'd2,
        PH_ONES2 = 4'd3,
        PH_ZERO  = 4'd4,
        PH_REQ   = 4'd5,
        PH_ACK   = 4'd6,
        PH_WDATA = 4'd7,
        PH_WPAR  = 4'd8,
        PH_RDATA = 4'd9,
        PH_RPAR  = 4'd10
    } t_phase;

    // Completion status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ACK  = 2'd1,
        ST_PAR_ERR = 2'd2
    } t_status;

    // Register map (word index)
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    localparam logic [15:0] SWITCH_KEY     = 16'hE79E;
    localparam logic [2:0]  ACK_OK         = 3'b001;
    localparam logic [4:0]  CONNECT_FIELDS = 5'h12;   // DP read, address 0

    localparam int IN_W  = 40;
    localparam int OUT_W = 40;

    // Bit slots per phase
    function automatic logic [6:0] phase_len(input t_phase ph);
        logic [6:0] len;
        case (ph)
            PH_ONES1: len = 7'd64;
            PH_KEY:   len = 7'd16;
            PH_ONES2: len = 7'd64;
            PH_ZERO:  len = 7'd8;
            PH_REQ:   len = 7'd8;
            PH_ACK:   len = 7'd3;
            PH_WDATA: len = 7'd32;
            PH_WPAR:  len = 7'd1;
            PH_RDATA: len = 7'd32;
            PH_RPAR:  len = 7'd1;
            default:  len = 7'd0;
        endcase
        return len;
    endfunction

    // Request byte: start, APnDP, RnW, A2, A3, parity, stop, park
    function automatic logic [7:0] request_byte(input logic [4:0] rf);
        logic par;
        par = rf[0] ^ rf[1] ^ rf[2] ^ rf[3];
        return {1'b1, 1'b0, par, rf[3], rf[2], rf[1], rf[0], 1'b1};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/swd_host_transfer_engine.sv
`default_nettype none

// Pin-level SWD host sequencer. Each transfer on the input stream is one system
// tick: it carries the command request and the sampled data-line level, and
// yields exactly one output transfer with the clock, data and drive-enable pin
// levels for that tick plus busy/done/status and the last read word. The
// engine takes one transfer per clock cycle into a single output register,
// and the input stalls only while that register holds a result the sink has
// not taken. The pin clock toggles each time the tick count reaches the
// half-period register (zero acts as one); transfers add turnarounds and
// retries as needed. Configuration writes go through the APB port only while
// the engine is idle; the user must ensure this, the block does not enforce it.
module swd_host_transfer_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // tdata: start_req[0], ap_select[1], read_select[2], address_bits[4:3],
    //        write_data[36:5], swdio_sample[37], zero pad[39:38]
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [swdhte_pkg::IN_W-1:0] i_s_axis_tdata,
    // tuser: cmd[0]
    input  wire logic                i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // tdata: clock_level[0], data_out[1], data_drive[2], busy_res[3],
    //        done_res[4], status[6:5], read_data[38:7], zero pad[39]
    output logic [swdhte_pkg::OUT_W-1:0] o_m_axis_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import swdhte_pkg::*;

    // Configuration
    logic [7:0]  r_half_period;
    logic [3:0]  r_retry_limit;

    // Sequencer state
    t_phase      r_phase,          n_phase;
    logic [6:0]  r_bit_count,      n_bit_count;
    logic [31:0] r_shift_word,     n_shift_word;
    logic [3:0]  r_tries_left,     n_tries_left;
    logic [7:0]  r_tick_count,     n_tick_count;
    logic        r_line_reading,   n_line_reading;
    logic        r_clock_high,     n_clock_high;
    logic [4:0]  r_request_fields, n_request_fields;
    logic [31:0] r_captured_word,  n_captured_word;
    logic [2:0]  r_ack_bits,       n_ack_bits;
    logic        r_last_level,     n_last_level;
    t_status     r_last_status,    n_last_status;

    // Output register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    logic        accept;
    logic        cfg_wr;
    logic [7:0]  half_eff;
    logic [7:0]  req_byte;
    logic        want_read, turn, drive, drv_bit, sample;
    logic        out_clk, out_dout, out_drive, out_busy, out_done;

    // Input fields
    logic        in_start, in_ap, in_read;
    logic [1:0]  in_addr;
    logic [31:0] in_wdata;

    assign in_start = i_s_axis_tdata[0];
    assign in_ap    = i_s_axis_tdata[1];
    assign in_read  = i_s_axis_tdata[2];
    assign in_addr  = i_s_axis_tdata[4:3];
    assign in_wdata = i_s_axis_tdata[36:5];
    assign sample   = i_s_axis_tdata[37];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {24'd0, r_half_period};
            REG_RETRY_LIMIT: prdata = {28'd0, r_retry_limit};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= 8'd1;
            r_retry_limit <= 4'd15;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_HALF_PERIOD: r_half_period <= pwdata[7:0];
                REG_RETRY_LIMIT: r_retry_limit <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    assign half_eff = (r_half_period == 8'd0) ? 8'd1 : r_half_period;

    // One tick of the sequencer
    always_comb begin
        n_phase          = r_phase;
        n_bit_count      = r_bit_count;
        n_shift_word     = r_shift_word;
        n_tries_left     = r_tries_left;
        n_tick_count     = r_tick_count;
        n_line_reading   = r_line_reading;
        n_clock_high     = r_clock_high;
        n_request_fields = r_request_fields;
        n_captured_word  = r_captured_word;
        n_ack_bits       = r_ack_bits;
        n_last_level     = r_last_level;
        n_last_status    = r_last_status;
        want_read        = 1'b0;
        turn             = 1'b0;
        drive            = 1'b0;
        drv_bit          = 1'b0;
        out_done         = 1'b0;

        // command launch
        if (r_phase == PH_IDLE && in_start) begin
            if (i_s_axis_tuser) begin
                n_request_fields = CONNECT_FIELDS;
                n_phase          = PH_ONES1;
            end else begin
                n_request_fields = {1'b0, in_addr, in_read, in_ap};
                n_phase          = PH_REQ;
            end
            n_shift_word = in_wdata;
            n_bit_count  = 7'd0;
            n_tick_count = 8'd0;
            n_clock_high = 1'b0;
            n_ack_bits   = 3'd0;
            n_tries_left = (r_retry_limit == 4'd0) ? 4'd1 : r_retry_limit;
        end

        req_byte = request_byte(n_request_fields);

        if (n_phase == PH_IDLE) begin
            out_clk   = n_clock_high;
            out_dout  = n_last_level;
            out_drive = !n_line_reading;
            out_busy  = 1'b0;
        end else begin
            want_read = (n_phase == PH_ACK) || (n_phase == PH_RDATA) || (n_phase == PH_RPAR);
            turn      = want_read != n_line_reading;
            drive     = !want_read && !turn;

            // bit the host places on the line this slot
            case (n_phase)
                PH_ONES1, PH_ONES2: drv_bit = 1'b1;
                PH_KEY:   drv_bit = SWITCH_KEY[n_bit_count[3:0]];
                PH_REQ:   drv_bit = req_byte[n_bit_count[2:0]];
                PH_WDATA: drv_bit = n_shift_word[n_bit_count[4:0]];
                PH_WPAR:  drv_bit = ^n_shift_word;
                default:  drv_bit = 1'b0;
            endcase

            if (turn)
                n_last_level = 1'b1;
            else if (drive)
                n_last_level = drv_bit;

            out_clk   = n_clock_high;
            out_dout  = n_last_level;
            out_drive = drive;
            out_busy  = 1'b1;

            n_tick_count = n_tick_count + 8'd1;
            if (n_tick_count >= half_eff) begin
                n_tick_count = 8'd0;
                if (!n_clock_high) begin
                    // sample at the end of the low half
                    if (want_read && !turn) begin
                        if (n_phase == PH_ACK)
                            n_ack_bits = n_ack_bits | (3'(sample) << n_bit_count[1:0]);
                        else if (n_phase == PH_RDATA)
                            n_shift_word = n_shift_word | (32'(sample) << n_bit_count[4:0]);
                        else
                            n_ack_bits = {2'b00, sample};
                    end
                    n_clock_high = 1'b1;
                end else begin
                    n_clock_high = 1'b0;
                    if (turn) begin
                        n_line_reading = want_read;
                    end else begin
                        n_bit_count = n_bit_count + 7'd1;
                        if (n_bit_count >= phase_len(n_phase)) begin
                            n_bit_count = 7'd0;
                            case (n_phase)
                                PH_ONES1: n_phase = PH_KEY;
                                PH_KEY:   n_phase = PH_ONES2;
                                PH_ONES2: n_phase = PH_ZERO;
                                PH_ZERO:  n_phase = PH_REQ;
                                PH_REQ: begin
                                    n_phase    = PH_ACK;
                                    n_ack_bits = 3'd0;
                                end
                                PH_ACK: begin
                                    if (n_ack_bits != ACK_OK) begin
                                        // failed attempt on acknowledge
                                        if (n_tries_left != 4'd0)
                                            n_tries_left = n_tries_left - 4'd1;
                                        if (n_tries_left == 4'd0) begin
                                            n_last_status = ST_NO_ACK;
                                            n_phase       = PH_IDLE;
                                            n_clock_high  = 1'b1;
                                            out_done      = 1'b1;
                                        end else begin
                                            n_phase = PH_REQ;
                                        end
                                    end else if (n_request_fields[1]) begin
                                        n_phase      = PH_RDATA;
                                        n_shift_word = 32'd0;
                                    end else begin
                                        n_phase = PH_WDATA;
                                    end
                                end
                                PH_WDATA: n_phase = PH_WPAR;
                                PH_RDATA: n_phase = PH_RPAR;
                                PH_RPAR: begin
                                    n_captured_word = n_shift_word;
                                    if ((^n_shift_word) == n_ack_bits[0]) begin
                                        n_last_status = ST_OK;
                                        n_phase       = PH_IDLE;
                                        n_clock_high  = 1'b1;
                                        out_done      = 1'b1;
                                    end else if (n_request_fields[0]) begin
                                        // AP read parity error retries
                                        if (n_tries_left != 4'd0)
                                            n_tries_left = n_tries_left - 4'd1;
                                        if (n_tries_left == 4'd0) begin
                                            n_last_status = ST_PAR_ERR;
                                            n_phase       = PH_IDLE;
                                            n_clock_high  = 1'b1;
                                            out_done      = 1'b1;
                                        end else begin
                                            n_phase = PH_REQ;
                                        end
                                    end else begin
                                        n_last_status = ST_PAR_ERR;
                                        n_phase       = PH_IDLE;
                                        n_clock_high  = 1'b1;
                                        out_done      = 1'b1;
                                    end
                                end
                                default: begin
                                    // write parity slot and unused codes complete OK
                                    n_last_status = ST_OK;
                                    n_phase       = PH_IDLE;
                                    n_clock_high  = 1'b1;
                                    out_done      = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
        end

        n_out_data = {1'b0, n_captured_word, n_last_status, out_done, out_busy,
                      out_drive, out_dout, out_clk};
    end

    // State registers, advanced once per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_bit_count      <= 7'd0;
            r_shift_word     <= 32'd0;
            r_tries_left     <= 4'd0;
            r_tick_count     <= 8'd0;
            r_line_reading   <= 1'b0;
            r_clock_high     <= 1'b1;
            r_request_fields <= 5'd0;
            r_captured_word  <= 32'd0;
            r_ack_bits       <= 3'd0;
            r_last_level     <= 1'b1;
            r_last_status    <= ST_OK;
        end else if (accept) begin
            r_phase          <= n_phase;
            r_bit_count      <= n_bit_count;
            r_shift_word     <= n_shift_word;
            r_tries_left     <= n_tries_left;
            r_tick_count     <= n_tick_count;
            r_line_reading   <= n_line_reading;
            r_clock_high     <= n_clock_high;
            r_request_fields <= n_request_fields;
            r_captured_word  <= n_captured_word;
            r_ack_bits       <= n_ack_bits;
            r_last_level     <= n_last_level;
            r_last_status    <= n_last_status;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire
